### hdl/hgk_pkg.sv
// Shared types, constants and elaboration-time functions for the Helmholtz kernel pipeline.
package hgk_pkg;

    localparam logic [63:0] INV4PI_Q64 = 64'h145F306DC9C882A5;
    localparam logic [63:0] INV2PI_Q64 = 64'h28BE60DB9391054A;
    localparam logic [34:0] TWOPI_Q32  = 35'd26986075409;
    localparam logic [63:0] PI4_Q62    = 64'h3243F6A8885A308D;
    localparam logic signed [63:0] KGAIN_Q40 = 64'sd667681663043;

    // One stage of the bit-pair square root.
    typedef struct packed {
        logic [63:0] v;
        logic [63:0] r;
    } t_sqrt_stage;

    // One stage of the restoring divider.
    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] q;
        logic [63:0] lo;
        logic [63:0] d;
        logic        sat;
    } t_div_stage;

    // One stage of the rotation CORDIC.
    typedef struct packed {
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
    } t_cordic_stage;

    // Long division by shift and subtract, used only on constants.
    function automatic logic [63:0] udiv_const(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            quo = {quo[62:0], 1'b0};
            if (rem >= {1'b0, den}) begin
                rem = rem - {1'b0, den};
                quo[0] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(2^-i) in Q.40 from the alternating series, truncated per term in Q.62.
    function automatic logic signed [63:0] atan_q40(input int i);
        logic [63:0] acc;
        logic [63:0] t;
        int          e;
        acc = '0;
        if (i == 0) begin
            return signed'((PI4_Q62 + (64'd1 << 21)) >> 22);
        end
        for (int n = 0; n < 64; n++) begin
            e = 62 - i * (2 * n + 1);
            if (e >= 0) begin
                t = udiv_const(64'd1 << e, 64'(2 * n + 1));
                acc = (n % 2 == 1) ? acc - t : acc + t;
            end
        end
        return signed'((acc + (64'd1 << 21)) >> 22);
    endfunction

endpackage

### hdl/hgk_if.sv
// Request channel interfaces: point pair input, kernel result output, wavenumber write.
interface hgk_in_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] sep_x;
    logic signed [COORD_WIDTH-1:0] sep_y;
    logic signed [COORD_WIDTH-1:0] sep_z;
    logic signed [COORD_WIDTH-1:0] norm_x;
    logic signed [COORD_WIDTH-1:0] norm_y;
    logic signed [COORD_WIDTH-1:0] norm_z;
    modport source(output valid, sep_x, sep_y, sep_z, norm_x, norm_y, norm_z, input ready);
    modport sink(input valid, sep_x, sep_y, sep_z, norm_x, norm_y, norm_z, output ready);
endinterface

interface hgk_out_if #(parameter int RESULT_WIDTH = 48);
    logic                           valid;
    logic                           ready;
    logic        [31:0]             distance;
    logic signed [RESULT_WIDTH-1:0] green_re;
    logic signed [RESULT_WIDTH-1:0] green_im;
    logic signed [RESULT_WIDTH-1:0] dgreen_re;
    logic signed [RESULT_WIDTH-1:0] dgreen_im;
    logic                           singular;
    modport source(output valid, distance, green_re, green_im, dgreen_re, dgreen_im,
                   singular, input ready);
    modport sink(input valid, distance, green_re, green_im, dgreen_re, dgreen_im,
                 singular, output ready);
endinterface

interface hgk_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

### hdl/hgk_delay.sv
// Shift line that carries side data alongside the pipeline.
module hgk_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_line [N];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_line[0] <= i_d;
            for (int j = 1; j < N; j++) begin
                r_line[j] <= r_line[j-1];
            end
        end
    end

    assign o_q = r_line[N-1];
endmodule

### hdl/hgk_mul.sv
// Two-stage 64x64 unsigned multiplier built from four 32x32 partial products.
module hgk_mul (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    output logic [127:0] o_p
);
    logic [63:0]  r_p00, r_p01, r_p10, r_p11;
    logic [127:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00 <= 64'(i_a[31:0]) * 64'(i_b[31:0]);
            r_p01 <= 64'(i_a[31:0]) * 64'(i_b[63:32]);
            r_p10 <= 64'(i_a[63:32]) * 64'(i_b[31:0]);
            r_p11 <= 64'(i_a[63:32]) * 64'(i_b[63:32]);
            r_p   <= {64'd0, r_p00} + ({64'd0, r_p01} << 32) + ({64'd0, r_p10} << 32)
                   + {r_p11, 64'd0};
        end
    end

    assign o_p = r_p;
endmodule

### hdl/hgk_sqrt_cell.sv
// One cell of the square root chain: decides one result bit.
module hgk_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  hgk_pkg::t_sqrt_stage i_d,
    output hgk_pkg::t_sqrt_stage o_q
);
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

    hgk_pkg::t_sqrt_stage r_q, n_q;
    logic [63:0]          trial;

    always_comb begin
        trial = i_d.r + BIT;
        if (i_d.v >= trial) begin
            n_q.v = i_d.v - trial;
            n_q.r = (i_d.r >> 1) + BIT;
        end else begin
            n_q.v = i_d.v;
            n_q.r = i_d.r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;
endmodule

### hdl/hgk_div_cell.sv
// One cell of the restoring divider: shifts in one dividend bit, yields one quotient bit.
module hgk_div_cell #(
    parameter int STEP = 0
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  hgk_pkg::t_div_stage i_d,
    output hgk_pkg::t_div_stage o_q
);
    localparam int BIT = 63 - STEP;

    hgk_pkg::t_div_stage r_q, n_q;
    logic [64:0]         shifted;
    logic                take;

    always_comb begin
        shifted = {i_d.rem, i_d.lo[BIT]};
        take    = shifted >= {1'b0, i_d.d};
        n_q     = i_d;
        n_q.rem = take ? 64'(shifted - {1'b0, i_d.d}) : shifted[63:0];
        n_q.q   = {i_d.q[62:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;
endmodule

### hdl/hgk_div.sv
// 128-by-64 divider as a chain of 64 cells, saturating when the quotient cannot fit.
module hgk_div (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_hi,
    input  logic [63:0] i_lo,
    input  logic [63:0] i_d,
    output logic [63:0] o_q
);
    hgk_pkg::t_div_stage chain [65];

    always_comb begin
        chain[0].rem = i_hi;
        chain[0].q   = '0;
        chain[0].lo  = i_lo;
        chain[0].d   = i_d;
        chain[0].sat = (i_d == '0) || (i_hi >= i_d);
    end

    for (genvar j = 0; j < 64; j++) begin : g_cell
        hgk_div_cell #(.STEP(j)) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_d   (chain[j]),
            .o_q   (chain[j+1])
        );
    end

    assign o_q = chain[64].sat ? '1 : chain[64].q;
endmodule

### hdl/hgk_cordic_cell.sv
// One rotation step of the CORDIC chain.
module hgk_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  hgk_pkg::t_cordic_stage i_d,
    output hgk_pkg::t_cordic_stage o_q
);
    localparam logic signed [63:0] ATAN = hgk_pkg::atan_q40(STEP);

    hgk_pkg::t_cordic_stage r_q, n_q;
    logic signed [63:0]     dx, dy;

    always_comb begin
        dx = i_d.y >>> STEP;
        dy = i_d.x >>> STEP;
        if (!i_d.z[63]) begin
            n_q.x = i_d.x - dx;
            n_q.y = i_d.y + dy;
            n_q.z = i_d.z - ATAN;
        end else begin
            n_q.x = i_d.x + dx;
            n_q.y = i_d.y - dy;
            n_q.z = i_d.z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;
endmodule

### hdl/helmholtz_green_kernel.sv
// Top level of the free-space Helmholtz kernel pipeline with its normal derivative.
//
//  Channel   Direction  Payload
//  i_in      sink       sep_x/y/z, norm_x/y/z (signed Q8.x)
//  o_res     source     distance, green_re/im, dgreen_re/im, singular
//  i_cfg     sink       wavenumber data (unsigned Q8.24), always ready
//
// One request is taken every cycle while the output is not stalled.
// The pipeline depth is set by the 32-cell square root followed by the two 64-cell dividers
// (1/(4 pi R), then the derivative scale), with the CORDIC running beside the first one.
// Reset clears the valid line and sets the wavenumber to zero.
// When a result is not taken, the whole pipeline holds and i_in.ready drops.
module helmholtz_green_kernel #(
    parameter int COORD_WIDTH  = 32,
    parameter int RESULT_WIDTH = 48,
    parameter int CORDIC_STEPS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hgk_in_if.sink     i_in,
    hgk_out_if.source  o_res,
    hgk_cfg_if.sink    i_cfg
);
    localparam int L_RR   = 35;
    localparam int L_P    = 36;
    localparam int L_DM   = 4;
    localparam int L_Q    = 39;
    localparam int L_CS   = 41 + CORDIC_STEPS;
    localparam int L_ROT  = L_CS + 1;
    localparam int L_ABS  = L_ROT + 1;
    localparam int L_KM   = L_ABS + 2;
    localparam int L_K    = L_KM + 1;
    localparam int L_A    = L_K + 1;
    localparam int L_AABS = L_A + 1;
    localparam int L_W    = L_RR + 64;
    localparam int L_EM   = L_W + 2;
    localparam int L_GR   = L_W + 3;
    localparam int L_E    = L_EM + 64;
    localparam int L_DR   = L_E + 3;
    localparam int L_OUT  = L_DR + 1;

    localparam int SH  = 96 - RESULT_WIDTH;
    localparam int RDW = 128 - SH;
    localparam logic [127:0] HALF = 128'd1 << (SH - 1);
    localparam logic [RDW-1:0] LIM_W = RDW'(1) << (RESULT_WIDTH - 1);
    localparam logic [RESULT_WIDTH-1:0] LIM_R = LIM_W[RESULT_WIDTH-1:0];
    localparam logic [RESULT_WIDTH-1:0] MAXPOS = LIM_R - 1'b1;

    function automatic logic [RESULT_WIDTH-1:0] sat_out(input logic neg,
                                                        input logic [RDW-1:0] m);
        logic [RESULT_WIDTH-1:0] mag;
        mag = (m > LIM_W) ? LIM_R : m[RESULT_WIDTH-1:0];
        if (!neg && mag == LIM_R) begin
            mag = MAXPOS;
        end
        return neg ? -mag : mag;
    endfunction

    logic                   adv;
    logic [L_OUT-1:0]       r_vld;
    logic [31:0]            r_k;

    logic signed [COORD_WIDTH-1:0] cin [6];
    logic signed [31:0]     cv [6];
    logic signed [31:0]     r_r [3];
    logic signed [31:0]     r_n [3];
    logic [63:0]            r_sq [3];
    logic signed [63:0]     r_rn [3];
    logic [63:0]            r_sqsum, r_pos, r_neg;
    logic                   r_dneg;
    logic [63:0]            r_dmag;

    hgk_pkg::t_sqrt_stage   sq_chain [33];
    logic [31:0]            rr;
    logic [63:0]            r_p, r_rr2;
    logic [63:0]            w;
    logic [127:0]           ph_prod;
    logic [31:0]            ph, ph_rnd;
    logic [1:0]             q_now;
    logic [1:0]             r_q;
    logic [31:0]            r_ph2;
    logic [31:0]            am;
    logic [66:0]            ang_prod;
    logic                   r_rneg;
    logic [39:0]            r_ang;
    logic signed [63:0]     r_z;
    hgk_pkg::t_cordic_stage cd_chain [CORDIC_STEPS+1];
    logic [1:0]             q_d;
    logic signed [63:0]     r_c, r_s;
    logic [63:0]            r_cm, r_sm;
    logic                   r_cneg, r_sneg;
    logic [55:0]            kr_d;
    logic [127:0]           ks_prod, kc_prod;
    logic [1:0]             sgn_d;
    logic signed [63:0]     ks_m, kc_m;
    logic signed [63:0]     r_ks, r_kc;
    logic signed [63:0]     c_d, s_d;
    logic signed [63:0]     r_are, r_aim;
    logic                   dneg_a;
    logic [63:0]            r_arem, r_aimm;
    logic                   r_aren, r_aimn;
    logic [63:0]            dmag_d, rr2_d;
    logic [127:0]           de_prod;
    logic [63:0]            e;
    logic [63:0]            cm_d, sm_d;
    logic                   cneg_d, sneg_d;
    logic [127:0]           gc_prod, gs_prod;
    logic [127:0]           gc_rnd, gs_rnd;
    logic [RDW-1:0]         r_gcr, r_gsr;
    logic                   r_gcn, r_gsn;
    logic [RDW-1:0]         gcr_d, gsr_d;
    logic                   gcn_d, gsn_d;
    logic [63:0]            arem_d, aimm_d;
    logic                   aren_d, aimn_d;
    logic [127:0]           dr_prod, di_prod;
    logic [127:0]           dr_rnd, di_rnd;
    logic [RDW-1:0]         r_drr, r_dir;
    logic                   r_drn, r_din;
    logic [31:0]            rr_out;
    logic [31:0]            r_o_dist;
    logic [RESULT_WIDTH-1:0] r_o_gre, r_o_gim, r_o_dre, r_o_dim;
    logic                   r_o_sing;

    assign adv        = !r_vld[L_OUT-1] || o_res.ready;
    assign i_in.ready = adv;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_k   <= '0;
        end else begin
            if (adv) begin
                r_vld <= {r_vld[L_OUT-2:0], i_in.valid};
            end
            if (i_cfg.valid) begin
                r_k <= i_cfg.data;
            end
        end
    end

    // Bring every coordinate to Q8.24.
    assign cin[0] = i_in.sep_x;
    assign cin[1] = i_in.sep_y;
    assign cin[2] = i_in.sep_z;
    assign cin[3] = i_in.norm_x;
    assign cin[4] = i_in.norm_y;
    assign cin[5] = i_in.norm_z;

    for (genvar i = 0; i < 6; i++) begin : g_coord
        if (COORD_WIDTH >= 32) begin : g_down
            assign cv[i] = 32'(cin[i] >>> (COORD_WIDTH - 32));
        end else begin : g_up
            assign cv[i] = 32'(cin[i]) <<< (32 - COORD_WIDTH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r_r[i]  <= cv[i];
                r_n[i]  <= cv[i+3];
                r_sq[i] <= 64'(64'(r_r[i]) * 64'(r_r[i]));
                r_rn[i] <= 64'(r_r[i]) * 64'(r_n[i]);
            end
            r_sqsum <= r_sq[0] + r_sq[1] + r_sq[2];
            r_pos   <= (r_rn[0][63] ? 64'd0 : r_rn[0]) + (r_rn[1][63] ? 64'd0 : r_rn[1])
                     + (r_rn[2][63] ? 64'd0 : r_rn[2]);
            r_neg   <= (r_rn[0][63] ? -r_rn[0] : 64'd0) + (r_rn[1][63] ? -r_rn[1] : 64'd0)
                     + (r_rn[2][63] ? -r_rn[2] : 64'd0);
            r_dneg  <= r_neg > r_pos;
            r_dmag  <= (r_neg > r_pos) ? r_neg - r_pos : r_pos - r_neg;
        end
    end

    // Square root, one result bit per cell.
    assign sq_chain[0].v = r_sqsum;
    assign sq_chain[0].r = '0;
    for (genvar j = 0; j < 32; j++) begin : g_sqrt
        hgk_sqrt_cell #(.STEP(j)) u_cell (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_d   (sq_chain[j]),
            .o_q   (sq_chain[j+1])
        );
    end
    assign rr = sq_chain[32].r[31:0];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p   <= 64'(r_k) * 64'(rr);
            r_rr2 <= 64'(rr) * 64'(rr);
        end
    end

    hgk_div u_div_w (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_hi  (64'd0),
        .i_lo  (hgk_pkg::INV4PI_Q64),
        .i_d   ({32'd0, rr}),
        .o_q   (w)
    );

    // Phase as a fraction of a turn, quadrant and residual angle.
    hgk_mul u_mul_ph (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_a   (r_p),
        .i_b   (hgk_pkg::INV2PI_Q64),
        .o_p   (ph_prod)
    );

    assign ph       = ph_prod[111:80];
    assign ph_rnd   = ph + 32'h2000_0000;
    assign q_now    = ph_rnd[31:30];
    assign am       = r_ph2[31] ? -r_ph2 : r_ph2;
    assign ang_prod = 67'(am) * 67'(hgk_pkg::TWOPI_Q32);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_q    <= q_now;
            r_ph2  <= ph - {q_now, 30'd0};
            r_rneg <= r_ph2[31];
            r_ang  <= ang_prod[63:24];
            r_z    <= r_rneg ? -64'(r_ang) : 64'(r_ang);
        end
    end

    assign cd_chain[0].x = hgk_pkg::KGAIN_Q40;
    assign cd_chain[0].y = '0;
    assign cd_chain[0].z = r_z;
    for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
        hgk_cordic_cell #(.STEP(j)) u_cell (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_d   (cd_chain[j]),
            .o_q   (cd_chain[j+1])
        );
    end

    hgk_delay #(.W(2), .N(L_CS - L_Q)) u_dly_q (
        .i_clk (i_clk), .i_en (adv), .i_d (r_q), .o_q (q_d)
    );

    always_ff @(posedge i_clk) begin
        if (adv) begin
            case (q_d)
                2'd0: begin
                    r_c <= cd_chain[CORDIC_STEPS].x;
                    r_s <= cd_chain[CORDIC_STEPS].y;
                end
                2'd1: begin
                    r_c <= -cd_chain[CORDIC_STEPS].y;
                    r_s <= cd_chain[CORDIC_STEPS].x;
                end
                2'd2: begin
                    r_c <= -cd_chain[CORDIC_STEPS].x;
                    r_s <= -cd_chain[CORDIC_STEPS].y;
                end
                default: begin
                    r_c <= cd_chain[CORDIC_STEPS].y;
                    r_s <= -cd_chain[CORDIC_STEPS].x;
                end
            endcase
            r_cm   <= r_c[63] ? -r_c : r_c;
            r_sm   <= r_s[63] ? -r_s : r_s;
            r_cneg <= r_c[63];
            r_sneg <= r_s[63];
        end
    end

    // kR times cos and sin for the derivative factor.
    hgk_delay #(.W(56), .N(L_ABS - L_P)) u_dly_kr (
        .i_clk (i_clk), .i_en (adv), .i_d (r_p[63:8]), .o_q (kr_d)
    );

    hgk_mul u_mul_ks (
        .i_clk (i_clk), .i_en (adv), .i_a ({8'd0, kr_d}), .i_b (r_sm), .o_p (ks_prod)
    );
    hgk_mul u_mul_kc (
        .i_clk (i_clk), .i_en (adv), .i_a ({8'd0, kr_d}), .i_b (r_cm), .o_p (kc_prod)
    );

    hgk_delay #(.W(2), .N(L_KM - L_ABS)) u_dly_sgn (
        .i_clk (i_clk), .i_en (adv), .i_d ({r_sneg, r_cneg}), .o_q (sgn_d)
    );
    hgk_delay #(.W(128), .N(L_K - L_ROT)) u_dly_cs (
        .i_clk (i_clk), .i_en (adv), .i_d ({r_c, r_s}), .o_q ({c_d, s_d})
    );
    hgk_delay #(.W(1), .N(L_A - L_DM)) u_dly_dneg (
        .i_clk (i_clk), .i_en (adv), .i_d (r_dneg), .o_q (dneg_a)
    );

    assign ks_m = ks_prod[103:40];
    assign kc_m = kc_prod[103:40];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ks   <= sgn_d[1] ? -ks_m : ks_m;
            r_kc   <= sgn_d[0] ? -kc_m : kc_m;
            r_are  <= -(c_d + r_ks);
            r_aim  <= r_kc - s_d;
            r_arem <= r_are[63] ? -r_are : r_are;
            r_aimm <= r_aim[63] ? -r_aim : r_aim;
            r_aren <= r_are[63] ^ dneg_a;
            r_aimn <= r_aim[63] ^ dneg_a;
        end
    end

    // Derivative scale e = |r.n| w / R^2.
    hgk_delay #(.W(64), .N(L_W - L_DM)) u_dly_dmag (
        .i_clk (i_clk), .i_en (adv), .i_d (r_dmag), .o_q (dmag_d)
    );
    hgk_delay #(.W(64), .N(L_EM - L_P)) u_dly_rr2 (
        .i_clk (i_clk), .i_en (adv), .i_d (r_rr2), .o_q (rr2_d)
    );

    hgk_mul u_mul_de (
        .i_clk (i_clk), .i_en (adv), .i_a (dmag_d), .i_b (w), .o_p (de_prod)
    );

    hgk_div u_div_e (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_hi  (de_prod[127:64]),
        .i_lo  (de_prod[63:0]),
        .i_d   (rr2_d),
        .o_q   (e)
    );

    // Kernel value.
    hgk_delay #(.W(130), .N(L_W - L_ABS)) u_dly_cm (
        .i_clk (i_clk), .i_en (adv), .i_d ({r_cm, r_sm, r_cneg, r_sneg}),
        .o_q ({cm_d, sm_d, cneg_d, sneg_d})
    );

    hgk_mul u_mul_gc (
        .i_clk (i_clk), .i_en (adv), .i_a (cm_d), .i_b (w), .o_p (gc_prod)
    );
    hgk_mul u_mul_gs (
        .i_clk (i_clk), .i_en (adv), .i_a (sm_d), .i_b (w), .o_p (gs_prod)
    );

    hgk_delay #(.W(2), .N(L_EM - L_W)) u_dly_gsgn (
        .i_clk (i_clk), .i_en (adv), .i_d ({cneg_d, sneg_d}), .o_q ({gcn_d, gsn_d})
    );

    assign gc_rnd = gc_prod + HALF;
    assign gs_rnd = gs_prod + HALF;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_gcr <= gc_rnd[127:SH];
            r_gsr <= gs_rnd[127:SH];
            r_gcn <= gcn_d;
            r_gsn <= gsn_d;
        end
    end

    logic [RDW-1:0] gcr_dd, gsr_dd;
    logic           gcn_dd, gsn_dd;

    hgk_delay #(.W(2 * RDW + 2), .N(L_DR - L_GR)) u_dly_g (
        .i_clk (i_clk), .i_en (adv), .i_d ({r_gcr, r_gsr, r_gcn, r_gsn}),
        .o_q ({gcr_dd, gsr_dd, gcn_dd, gsn_dd})
    );
    assign gcr_d = gcr_dd;
    assign gsr_d = gsr_dd;

    // Normal derivative.
    hgk_delay #(.W(130), .N(L_E - L_AABS)) u_dly_a (
        .i_clk (i_clk), .i_en (adv), .i_d ({r_arem, r_aimm, r_aren, r_aimn}),
        .o_q ({arem_d, aimm_d, aren_d, aimn_d})
    );

    hgk_mul u_mul_dr (
        .i_clk (i_clk), .i_en (adv), .i_a (arem_d), .i_b (e), .o_p (dr_prod)
    );
    hgk_mul u_mul_di (
        .i_clk (i_clk), .i_en (adv), .i_a (aimm_d), .i_b (e), .o_p (di_prod)
    );

    logic aren_m, aimn_m;

    hgk_delay #(.W(2), .N(2)) u_dly_asgn (
        .i_clk (i_clk), .i_en (adv), .i_d ({aren_d, aimn_d}), .o_q ({aren_m, aimn_m})
    );

    assign dr_rnd = dr_prod + HALF;
    assign di_rnd = di_prod + HALF;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_drr <= dr_rnd[127:SH];
            r_dir <= di_rnd[127:SH];
            r_drn <= aren_m;
            r_din <= aimn_m;
        end
    end

    hgk_delay #(.W(32), .N(L_DR - L_RR)) u_dly_rr (
        .i_clk (i_clk), .i_en (adv), .i_d (rr), .o_q (rr_out)
    );

    // Output register: saturation and the zero-separation override.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_dist <= rr_out;
            r_o_sing <= (rr_out == '0);
            if (rr_out == '0) begin
                r_o_gre <= MAXPOS;
                r_o_gim <= MAXPOS;
                r_o_dre <= MAXPOS;
                r_o_dim <= MAXPOS;
            end else begin
                r_o_gre <= sat_out(gcn_dd, gcr_d);
                r_o_gim <= sat_out(gsn_dd, gsr_d);
                r_o_dre <= sat_out(r_drn, r_drr);
                r_o_dim <= sat_out(r_din, r_dir);
            end
        end
    end

    assign o_res.valid     = r_vld[L_OUT-1];
    assign o_res.distance  = r_o_dist;
    assign o_res.green_re  = r_o_gre;
    assign o_res.green_im  = r_o_gim;
    assign o_res.dgreen_re = r_o_dre;
    assign o_res.dgreen_im = r_o_dim;
    assign o_res.singular  = r_o_sing;

`ifndef SYNTHESIS
    a_sing_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.singular == (o_res.distance == '0)))
        else $error("singular flag disagrees with distance");

    a_sing_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.singular) |->
            (r_o_gre == MAXPOS && r_o_gim == MAXPOS && r_o_dre == MAXPOS
             && r_o_dim == MAXPOS))
        else $error("singular result not saturated");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_res.valid |-> i_in.ready)
        else $error("input stalled with an empty output register");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("valid line not cleared by reset");
`endif
endmodule
